// File: src/vtp_pkg.sv
// package: types, widths and constants for the vertex transform with perspective divide
`default_nettype none

package vtp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IN_W      = 32;
    localparam int CFG_W     = 64;
    localparam int NREG      = 8;
    localparam int CFG_IDX_W = 4;
    localparam int LANES     = 3;

    localparam int PROD_W    = 2 * IN_W;
    localparam int TRN_W     = IN_W + FRAC_BITS;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ACC_W     = PROD_W + 2;
    localparam int ABS_W     = ACC_W - 1;
    localparam int DIV_STEPS = DATA_WIDTH + 1;
    localparam int PRE_SH    = DIV_STEPS - FRAC_BITS;

    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + 32);

    typedef struct packed {
        logic signed [IN_W-1:0] in_x;
        logic signed [IN_W-1:0] in_y;
        logic signed [IN_W-1:0] in_z;
    } t_vtp_in;

    typedef struct packed {
        logic signed [IN_W-1:0] out_x;
        logic signed [IN_W-1:0] out_y;
        logic signed [IN_W-1:0] out_z;
        logic signed [IN_W-1:0] out_w;
        logic                   w_zero;
        logic                   saturated;
    } t_vtp_out;

    // one division lane: partial remainder, divisor and the numerator/quotient shift word
    typedef struct packed {
        logic [ABS_W-1:0]     rem;
        logic [ABS_W-1:0]     den;
        logic [DIV_STEPS-1:0] bits;
    } t_div;

endpackage

`default_nettype wire

// File: src/vtp_div_cell.sv
// one restoring division step: one quotient bit per cell
`default_nettype none

module vtp_div_cell
    import vtp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_div,
    output t_div      o_div
);

    logic [ABS_W:0]   trial;
    logic [ABS_W+1:0] diff;
    logic             ge;
    t_div             n_div;
    t_div             r_div;

    always_comb begin
        trial = {i_div.rem, i_div.bits[DIV_STEPS-1]};
        diff  = {1'b0, trial} - {2'b00, i_div.den};
        ge    = ~diff[ABS_W+1];
        n_div.den  = i_div.den;
        n_div.rem  = ge ? diff[ABS_W-1:0] : trial[ABS_W-1:0];
        n_div.bits = {i_div.bits[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

// File: src/vtp_div_chain.sv
// row of division cells, one quotient bit resolved per stage
`default_nettype none

module vtp_div_chain
    import vtp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_div,
    output t_div      o_div
);

    t_div link [DIV_STEPS+1];

    assign link[0] = i_div;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        vtp_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_div (link[k]),
            .o_div (link[k+1])
        );
    end

    assign o_div = link[DIV_STEPS];

endmodule

`default_nettype wire

// File: src/vertex_transform_perspective_divide.sv
// top level: 4x4 vertex transform, perspective divide and saturation
//
// input channel: i_valid / o_ready carry one vertex (x, y, z, Q16.16) per item,
// w is taken as 1. output channel: o_valid / i_ready carry the transformed
// x/w, y/w, z/w (x, y, z when w is zero), w and the w_zero and saturated flags.
// the matrix sits in eight 64-bit registers written through i_cfg_we,
// i_cfg_idx and i_cfg_data; indexes of eight and above are ignored.
// stages: products, two adder levels, magnitude prep, one division cell per
// quotient bit (33 cells) and the output register. throughput is one item
// per cycle while the output is taken; the division row is the long part.
// the whole pipe advances together: when the output item is not taken,
// o_ready drops and every stage holds, otherwise items flow every cycle.
// reset (synchronous, active low) empties the pipe and loads the identity matrix.
`default_nettype none

module vertex_transform_perspective_divide
    import vtp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_vtp_in              i_vtx,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_vtp_out                  o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int NSTG = 5 + DIV_STEPS;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic [DIV_STEPS-1:0] Q_POS_MAX = {2'b00, {(DATA_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic                   neg;
        logic                   ovf;
        logic signed [IN_W-1:0] alt;
        logic                   alt_sat;
    } t_lane_side;

    typedef struct packed {
        t_lane_side [LANES-1:0] lane;
        logic                   w_zero;
        logic signed [IN_W-1:0] w;
        logic                   w_sat;
    } t_side;

    typedef struct packed {
        logic signed [IN_W-1:0] val;
        logic                   sat;
    } t_satv;

    function automatic logic signed [IN_W-1:0] sext_entry(input logic [31:0] v);
        logic signed [DATA_WIDTH-1:0] t;
        t = v[DATA_WIDTH-1:0];
        return IN_W'(t);
    endfunction

    function automatic t_satv sat_acc(input logic signed [ACC_W-1:0] v);
        t_satv                        s;
        logic signed [DATA_WIDTH-1:0] t;
        if (v > SAT_MAX) begin
            t = SAT_MAX[DATA_WIDTH-1:0];
            s.sat = 1'b1;
        end else if (v < SAT_MIN) begin
            t = SAT_MIN[DATA_WIDTH-1:0];
            s.sat = 1'b1;
        end else begin
            t = v[DATA_WIDTH-1:0];
            s.sat = 1'b0;
        end
        s.val = IN_W'(t);
        return s;
    endfunction

    // final signed quotient from the magnitude, with clamping
    function automatic t_satv sat_quo(input logic [DIV_STEPS-1:0] q, input logic neg,
                                      input logic ovf);
        t_satv                        s;
        logic signed [DATA_WIDTH-1:0] t;
        logic [DIV_STEPS-1:0]         nq;
        nq = -q;
        if (ovf || (!neg && q > Q_POS_MAX) || (neg && q > Q_POS_MAX + 1'b1)) begin
            t = neg ? SAT_MIN[DATA_WIDTH-1:0] : SAT_MAX[DATA_WIDTH-1:0];
            s.sat = 1'b1;
        end else begin
            t = neg ? nq[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
            s.sat = 1'b0;
        end
        s.val = IN_W'(t);
        return s;
    endfunction

    logic [CFG_W-1:0] r_mat [NREG];
    logic [NSTG-1:0]  r_vld;
    logic             en;

    logic signed [IN_W-1:0]   ev  [4][4];
    logic signed [IN_W-1:0]   vin [LANES];
    logic signed [PROD_W-1:0] r_prod [4][LANES];
    logic signed [TRN_W-1:0]  r_trn  [4];
    logic signed [SUM_W-1:0]  r_psa  [4];
    logic signed [SUM_W-1:0]  r_psb  [4];
    logic signed [ACC_W-1:0]  r_acc  [4];
    logic [ABS_W-1:0]         r_abs  [4];
    t_side                    n_s4;
    t_side                    r_s4;
    t_side                    n_sb0;
    t_side                    r_sb [DIV_STEPS];
    t_div                     div_in  [LANES];
    t_div                     div_out [LANES];
    t_satv                    lane_res [LANES];
    t_vtp_out                 n_res;
    t_vtp_out                 r_res;

    assign en      = ~r_vld[NSTG-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];
    assign o_res   = r_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= ONE_LO;
            r_mat[1] <= '0;
            r_mat[2] <= ONE_HI;
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= ONE_LO;
            r_mat[6] <= '0;
            r_mat[7] <= ONE_HI;
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NREG)) begin
            r_mat[i_cfg_idx[$clog2(NREG)-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            ev[r][0] = sext_entry(r_mat[2*r][31:0]);
            ev[r][1] = sext_entry(r_mat[2*r][63:32]);
            ev[r][2] = sext_entry(r_mat[2*r+1][31:0]);
            ev[r][3] = sext_entry(r_mat[2*r+1][63:32]);
        end
        vin[0] = sext_entry(i_vtx.in_x);
        vin[1] = sext_entry(i_vtx.in_y);
        vin[2] = sext_entry(i_vtx.in_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // products, adder levels and magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < LANES; r++) begin
                    r_prod[c][r] <= PROD_W'(vin[r]) * PROD_W'(ev[r][c]);
                end
                r_trn[c] <= {ev[3][c], {FRAC_BITS{1'b0}}};
                r_psa[c] <= SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1]);
                r_psb[c] <= SUM_W'(r_prod[c][2]) + SUM_W'(r_trn[c]);
                r_acc[c] <= ACC_W'(r_psa[c]) + ACC_W'(r_psb[c]);
                r_abs[c] <= r_acc[c][ACC_W-1] ? ABS_W'(-r_acc[c]) : ABS_W'(r_acc[c]);
            end
            r_s4 <= n_s4;
        end
    end

    always_comb begin
        t_satv sw;
        t_satv sl;
        sw = sat_acc(r_acc[3] >>> FRAC_BITS);
        n_s4.w_zero = (r_acc[3] == '0);
        n_s4.w      = sw.val;
        n_s4.w_sat  = sw.sat;
        for (int c = 0; c < LANES; c++) begin
            sl = sat_acc(r_acc[c] >>> FRAC_BITS);
            n_s4.lane[c].neg     = r_acc[c][ACC_W-1] ^ r_acc[3][ACC_W-1];
            n_s4.lane[c].ovf     = 1'b0;
            n_s4.lane[c].alt     = sl.val;
            n_s4.lane[c].alt_sat = sl.sat;
        end
    end

    // quotient too large for the division row when |n| >> 17 >= |w|
    always_comb begin
        n_sb0 = r_s4;
        for (int c = 0; c < LANES; c++) begin
            div_in[c].rem  = ABS_W'(r_abs[c] >> PRE_SH);
            div_in[c].den  = r_abs[3];
            div_in[c].bits = DIV_STEPS'(r_abs[c] << FRAC_BITS);
            n_sb0.lane[c].ovf = (ABS_W'(r_abs[c] >> PRE_SH) >= r_abs[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb0;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        vtp_div_chain u_chain (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (div_in[c]),
            .o_div (div_out[c])
        );
    end

    always_comb begin
        t_side sb;
        sb = r_sb[DIV_STEPS-1];
        for (int c = 0; c < LANES; c++) begin
            if (sb.w_zero) begin
                lane_res[c].val = sb.lane[c].alt;
                lane_res[c].sat = sb.lane[c].alt_sat;
            end else begin
                lane_res[c] = sat_quo(div_out[c].bits, sb.lane[c].neg, sb.lane[c].ovf);
            end
        end
        n_res.out_x     = lane_res[0].val;
        n_res.out_y     = lane_res[1].val;
        n_res.out_z     = lane_res[2].val;
        n_res.out_w     = sb.w;
        n_res.w_zero    = sb.w_zero;
        n_res.saturated = sb.w_sat | lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    a_wzero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.w_zero |-> o_res.out_w == '0)
        else $error("w_zero item with nonzero w");

    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("item present straight after reset");

    a_hold_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("pipe held without a stalled output item");

endmodule

`default_nettype wire
